// ----- sv/cubic_bezier_point_generator_unit_assert.svh -----
// Assertion macros shared by the cubic Bezier point generator RTL.
// No dependencies; expects a clock and an active-low reset to be passed in.
`ifndef CUBIC_BEZIER_POINT_GENERATOR_UNIT_ASSERT_SVH
`define CUBIC_BEZIER_POINT_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBPG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CBPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cbpg_pkg.sv -----
// Shared constants for the cubic Bezier point generator.
// No dependencies; imported by cubic_bezier_point_generator_unit and tb_top.
package cbpg_pkg;

    // Field widths
    localparam int INDEX_W = 11;
    localparam int COORD_W = 16;
    localparam int PIXEL_W = 12;
    localparam int NUM_REGS = 8;
    localparam int REG_INDEX_W = 3;

    // Parameter defaults
    localparam int SAMPLES_DEFAULT = 2048;
    localparam int COORD_FRAC_BITS_DEFAULT = 12;

    // t in unsigned Q1.16, weights scaled by 2^48
    localparam int T_FRAC_BITS = 16;
    localparam int T_W = T_FRAC_BITS + 1;
    localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC_BITS;
    localparam int WEIGHT_FRAC_BITS = 3 * T_FRAC_BITS;
    localparam int WEIGHT_W = WEIGHT_FRAC_BITS + 1;

    // Pixel mapping
    localparam logic signed [8:0] PIX_SCALE_X = 9'sd160;
    localparam logic signed [8:0] PIX_SCALE_Y = 9'sd100;
    localparam int PIX_OFF_X = 252;
    localparam int PIX_OFF_Y = 42;
    localparam int PIX_MIN = -(1 << (PIXEL_W - 1));
    localparam int PIX_MAX = (1 << (PIXEL_W - 1)) - 1;

    // Register map
    typedef enum logic [REG_INDEX_W-1:0] {
        REG_CTRL_X0 = 3'd0,
        REG_CTRL_X1 = 3'd1,
        REG_CTRL_X2 = 3'd2,
        REG_CTRL_X3 = 3'd3,
        REG_CTRL_Y0 = 3'd4,
        REG_CTRL_Y1 = 3'd5,
        REG_CTRL_Y2 = 3'd6,
        REG_CTRL_Y3 = 3'd7
    } cbpg_reg_t;

    localparam logic signed [COORD_W-1:0] CTRL_RESET [NUM_REGS] = '{
        -16'sd819, 16'sd8192, -16'sd4096, 16'sd4915,
        -16'sd819, 16'sd4096, 16'sd4096, -16'sd819
    };

endpackage

// ----- sv/cubic_bezier_point_generator_unit.sv -----
// Cubic Bezier point generator: sample index in, curve point and pixel out.
// Depends on cbpg_pkg and cubic_bezier_point_generator_unit_assert.svh.
//   Input: pulse start with sample_index; the item is taken on any rising
//   edge where start is high and busy is low. busy never rises: the datapath
//   is a nine-stage pipeline with no stall, so one item enters every cycle.
//   Output: done is high for exactly one cycle with curve_x, curve_y,
//   pixel_x and pixel_y. The receiver cannot hold results off, and none is
//   needed: results leave in order at one per cycle.
//   Stages, in order: reciprocal multiply, divide correction, squares,
//   cubes, coordinate products, pair sums, final sum and rounding, pixel
//   scaling, pixel offset and saturation.
//   Throughput: 1 item per cycle; nothing ever stalls the pipeline.
//   Configuration: wr_en/wr_index/wr_data write the eight control
//   coordinates (X0..X3, Y0..Y3, signed Q3.12). Write only while the
//   pipeline is empty; items in flight use the live registers.
//   Reset: rst_n clears the valid chain and loads the default control
//   points; no clearing pass, the block takes items as soon as reset is
//   released.
//   t = round(index * 65536 / (SAMPLES-1)), index clamped to SAMPLES-1.
module cubic_bezier_point_generator_unit #(
    parameter int SAMPLES         = cbpg_pkg::SAMPLES_DEFAULT,
    parameter int COORD_FRAC_BITS = cbpg_pkg::COORD_FRAC_BITS_DEFAULT
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic [cbpg_pkg::INDEX_W-1:0]             sample_index,
    input  logic                                     wr_en,
    input  logic [cbpg_pkg::REG_INDEX_W-1:0]         wr_index,
    input  logic [cbpg_pkg::COORD_W-1:0]             wr_data,
    output logic                                     done,
    output logic signed [cbpg_pkg::COORD_W-1:0]      curve_x,
    output logic signed [cbpg_pkg::COORD_W-1:0]      curve_y,
    output logic signed [cbpg_pkg::PIXEL_W-1:0]      pixel_x,
    output logic signed [cbpg_pkg::PIXEL_W-1:0]      pixel_y
);
    import cbpg_pkg::*;

    `include "cubic_bezier_point_generator_unit_assert.svh"

    localparam int STAGES = 9;

    // Divisor and its reciprocal: q_est = (n * RECIP) >> 32 is q or q-1
    // for any n below 2^28.
    localparam int unsigned DEN = (SAMPLES > 1) ? SAMPLES - 1 : 1;
    localparam int N_W = INDEX_W + T_FRAC_BITS + 1;
    localparam int RECIP_SHIFT = 32;
    localparam logic [16:0] DEN_W = 17'(DEN);
    localparam logic [32:0] RECIP = 33'((64'd1 << RECIP_SHIFT) / 64'(DEN));
    localparam logic [N_W-1:0] N_BIAS = N_W'(DEN / 2);
    localparam int PROD1_W = N_W + 33;

    localparam int SQ_W = 2 * T_FRAC_BITS + 1;   // t^2, u^2 up to 2^32
    localparam int TU_W = 2 * T_FRAC_BITS - 1;   // t*u up to 2^30
    localparam int CUBE_W = SQ_W + T_W;
    localparam int ACC_W = COORD_W + WEIGHT_W + 1;
    localparam int RND_W = ACC_W - WEIGHT_FRAC_BITS;
    localparam int SCL_W = COORD_W + 9;

    // ---------------- control registers
    logic signed [COORD_W-1:0] ctrl_reg [NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_REGS; k++)
            begin
                ctrl_reg[k] <= CTRL_RESET[k];
            end
        end
        else if (wr_en)
        begin
            ctrl_reg[wr_index] <= wr_data;
        end
    end

    // ---------------- valid chain
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic              accept;

    assign busy       = 1'b0;
    assign accept     = start & ~busy;
    assign valid_next = {valid_reg[STAGES-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign done = valid_reg[STAGES-1];

    // ---------------- stage 1: clamp index, reciprocal multiply
    logic [INDEX_W-1:0] idx_clamped;
    logic [N_W-1:0]     n_next, n_reg;
    logic [PROD1_W-1:0] prod1;
    logic [T_W-1:0]     q_est_next, q_est_reg;

    always_comb
    begin
        if (17'(sample_index) > DEN_W)
        begin
            idx_clamped = DEN_W[INDEX_W-1:0];
        end
        else
        begin
            idx_clamped = sample_index;
        end
        n_next     = N_W'({idx_clamped, {T_FRAC_BITS{1'b0}}}) + N_BIAS;
        prod1      = PROD1_W'(n_next) * PROD1_W'(RECIP);
        q_est_next = prod1[RECIP_SHIFT +: T_W];
    end

    // ---------------- stage 2: quotient correction, t and 1-t
    logic [33:0]    qd;
    logic [N_W-1:0] rem;
    logic [T_W:0]   t_fix;
    logic [T_W-1:0] t_next, t_reg;
    logic [T_W-1:0] u_next, u_reg;

    always_comb
    begin
        qd    = 34'(q_est_reg) * 34'(DEN_W);
        rem   = n_reg - qd[N_W-1:0];
        t_fix = (rem >= N_W'(DEN_W)) ? ((T_W+1)'(q_est_reg) + 1'b1) : (T_W+1)'(q_est_reg);
        if (t_fix > (T_W+1)'(T_ONE))
        begin
            t_next = T_ONE;
        end
        else
        begin
            t_next = t_fix[T_W-1:0];
        end
        u_next = T_ONE - t_next;
    end

    // ---------------- stage 3: squares and cross term
    logic [SQ_W-1:0] t2_next, t2_reg;
    logic [SQ_W-1:0] u2_next, u2_reg;
    logic [TU_W-1:0] tu_next, tu_reg;
    logic [T_W-1:0]  t3_reg, u3_reg;
    logic [2*T_W-1:0] sq_t, sq_u, sq_tu;

    always_comb
    begin
        sq_t    = (2*T_W)'(t_reg) * (2*T_W)'(t_reg);
        sq_u    = (2*T_W)'(u_reg) * (2*T_W)'(u_reg);
        sq_tu   = (2*T_W)'(t_reg) * (2*T_W)'(u_reg);
        t2_next = sq_t[SQ_W-1:0];
        u2_next = sq_u[SQ_W-1:0];
        tu_next = sq_tu[TU_W-1:0];
    end

    // ---------------- stage 4: Bernstein weights, sum is 2^48
    logic [WEIGHT_W-1:0] w_next [4];
    logic [WEIGHT_W-1:0] w_reg  [4];
    logic [CUBE_W-1:0]   c_uuu, c_uut, c_utt, c_ttt;
    logic [CUBE_W+1:0]   c3_uut, c3_utt;

    always_comb
    begin
        c_uuu  = CUBE_W'(u2_reg) * CUBE_W'(u3_reg);
        c_uut  = CUBE_W'(u2_reg) * CUBE_W'(t3_reg);
        c_utt  = CUBE_W'(tu_reg) * CUBE_W'(t3_reg);
        c_ttt  = CUBE_W'(t2_reg) * CUBE_W'(t3_reg);
        c3_uut = {c_uut, 1'b0} + (CUBE_W+2)'(c_uut);
        c3_utt = {c_utt, 1'b0} + (CUBE_W+2)'(c_utt);
        w_next[0] = c_uuu[WEIGHT_W-1:0];
        w_next[1] = c3_uut[WEIGHT_W-1:0];
        w_next[2] = c3_utt[WEIGHT_W-1:0];
        w_next[3] = c_ttt[WEIGHT_W-1:0];
    end

    // ---------------- stage 5: coordinate x weight
    logic signed [ACC_W-1:0] px_next [4];
    logic signed [ACC_W-1:0] py_next [4];
    logic signed [ACC_W-1:0] px_reg  [4];
    logic signed [ACC_W-1:0] py_reg  [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            px_next[k] = ACC_W'(ctrl_reg[k]) * ACC_W'($signed({1'b0, w_reg[k]}));
            py_next[k] = ACC_W'(ctrl_reg[k+4]) * ACC_W'($signed({1'b0, w_reg[k]}));
        end
    end

    // ---------------- stage 6: pair sums
    logic signed [ACC_W-1:0] sx01_reg, sx23_reg, sy01_reg, sy23_reg;

    // ---------------- stage 7: final sum, round half up, clamp
    logic signed [ACC_W-1:0]   sum_x, sum_y;
    logic signed [RND_W-1:0]   rnd_x, rnd_y;
    logic signed [COORD_W-1:0] cx_next, cy_next, cx_reg, cy_reg;

    localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) <<< (WEIGHT_FRAC_BITS - 1);
    localparam logic signed [RND_W-1:0] C_MIN = RND_W'(-(1 << (COORD_W - 1)));
    localparam logic signed [RND_W-1:0] C_MAX = RND_W'((1 << (COORD_W - 1)) - 1);

    always_comb
    begin
        sum_x = sx01_reg + sx23_reg + RND_BIAS;
        sum_y = sy01_reg + sy23_reg + RND_BIAS;
        rnd_x = sum_x[ACC_W-1:WEIGHT_FRAC_BITS];
        rnd_y = sum_y[ACC_W-1:WEIGHT_FRAC_BITS];
        if (rnd_x < C_MIN)
        begin
            cx_next = C_MIN[COORD_W-1:0];
        end
        else if (rnd_x > C_MAX)
        begin
            cx_next = C_MAX[COORD_W-1:0];
        end
        else
        begin
            cx_next = rnd_x[COORD_W-1:0];
        end
        if (rnd_y < C_MIN)
        begin
            cy_next = C_MIN[COORD_W-1:0];
        end
        else if (rnd_y > C_MAX)
        begin
            cy_next = C_MAX[COORD_W-1:0];
        end
        else
        begin
            cy_next = rnd_y[COORD_W-1:0];
        end
    end

    // ---------------- stage 8: pixel scaling
    logic signed [SCL_W-1:0]   scl_x_next, scl_y_next, scl_x_reg, scl_y_reg;
    logic signed [COORD_W-1:0] cx8_reg, cy8_reg;

    assign scl_x_next = SCL_W'(cx_reg) * SCL_W'(PIX_SCALE_X);
    assign scl_y_next = SCL_W'(cy_reg) * SCL_W'(PIX_SCALE_Y);

    // ---------------- stage 9: truncate toward zero, offset, saturate
    localparam logic signed [SCL_W-1:0] FRAC_MASK = SCL_W'((1 << COORD_FRAC_BITS) - 1);
    localparam logic signed [SCL_W-1:0] P_MIN = SCL_W'(PIX_MIN);
    localparam logic signed [SCL_W-1:0] P_MAX = SCL_W'(PIX_MAX);

    logic signed [SCL_W-1:0]   adj_x, adj_y, pv_x, pv_y;
    logic signed [PIXEL_W-1:0] pix_x_next, pix_y_next;
    logic signed [COORD_W-1:0] curve_x_reg, curve_y_reg;
    logic signed [PIXEL_W-1:0] pixel_x_reg, pixel_y_reg;

    always_comb
    begin
        adj_x = scl_x_reg + (scl_x_reg[SCL_W-1] ? FRAC_MASK : '0);
        adj_y = scl_y_reg + (scl_y_reg[SCL_W-1] ? FRAC_MASK : '0);
        pv_x  = (adj_x >>> COORD_FRAC_BITS) + SCL_W'(PIX_OFF_X);
        pv_y  = (adj_y >>> COORD_FRAC_BITS) + SCL_W'(PIX_OFF_Y);
        if (pv_x < P_MIN)
        begin
            pix_x_next = P_MIN[PIXEL_W-1:0];
        end
        else if (pv_x > P_MAX)
        begin
            pix_x_next = P_MAX[PIXEL_W-1:0];
        end
        else
        begin
            pix_x_next = pv_x[PIXEL_W-1:0];
        end
        if (pv_y < P_MIN)
        begin
            pix_y_next = P_MIN[PIXEL_W-1:0];
        end
        else if (pv_y > P_MAX)
        begin
            pix_y_next = P_MAX[PIXEL_W-1:0];
        end
        else
        begin
            pix_y_next = pv_y[PIXEL_W-1:0];
        end
    end

    // ---------------- datapath registers (no reset; qualified by valid_reg)
    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        q_est_reg <= q_est_next;
        t_reg     <= t_next;
        u_reg     <= u_next;
        t2_reg    <= t2_next;
        u2_reg    <= u2_next;
        tu_reg    <= tu_next;
        t3_reg    <= t_reg;
        u3_reg    <= u_reg;
        for (int k = 0; k < 4; k++)
        begin
            w_reg[k]  <= w_next[k];
            px_reg[k] <= px_next[k];
            py_reg[k] <= py_next[k];
        end
        sx01_reg    <= px_reg[0] + px_reg[1];
        sx23_reg    <= px_reg[2] + px_reg[3];
        sy01_reg    <= py_reg[0] + py_reg[1];
        sy23_reg    <= py_reg[2] + py_reg[3];
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        scl_x_reg   <= scl_x_next;
        scl_y_reg   <= scl_y_next;
        cx8_reg     <= cx_reg;
        cy8_reg     <= cy_reg;
        curve_x_reg <= cx8_reg;
        curve_y_reg <= cy8_reg;
        pixel_x_reg <= pix_x_next;
        pixel_y_reg <= pix_y_next;
    end

    assign curve_x = curve_x_reg;
    assign curve_y = curve_y_reg;
    assign pixel_x = pixel_x_reg;
    assign pixel_y = pixel_y_reg;

    // ---------------- assertions
    logic t_ok, sq_ok, w_ok;

    assign t_ok  = (t_reg <= T_ONE)
                   && ((T_W+1)'(t_reg) + (T_W+1)'(u_reg) == (T_W+1)'(T_ONE));
    assign sq_ok = (SQ_W+2)'(t2_reg) + ((SQ_W+2)'(tu_reg) <<< 1) + (SQ_W+2)'(u2_reg)
                   == ((SQ_W+2)'(1) <<< (2*T_FRAC_BITS));
    assign w_ok  = (WEIGHT_W+2)'(w_reg[0]) + (WEIGHT_W+2)'(w_reg[1])
                   + (WEIGHT_W+2)'(w_reg[2]) + (WEIGHT_W+2)'(w_reg[3])
                   == ((WEIGHT_W+2)'(1) <<< WEIGHT_FRAC_BITS);

    `CBPG_ASSERT_IMPLIES(a_t_range, clk, rst_n, valid_reg[1], t_ok, "t or 1-t out of range")
    `CBPG_ASSERT_NEXT(a_square_sum, clk, rst_n, valid_reg[1], sq_ok, "squares do not sum to one")
    `CBPG_ASSERT_IMPLIES(a_weight_sum, clk, rst_n, valid_reg[3], w_ok, "weights do not sum to one")

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for cubic_bezier_point_generator_unit: random sample indices
// under several control-point settings, checked against an in-bench Bezier predictor.
// Depends on cbpg_pkg and the RTL of the block.
module tb_top;
    import cbpg_pkg::*;

    localparam int CLK_HALF   = 5;
    localparam int SAMPLE_CNT = SAMPLES_DEFAULT;
    localparam int FRAC_BITS  = COORD_FRAC_BITS_DEFAULT;
    localparam int IDLE_PCT   = 37;
    localparam int DRAIN_CYC  = 20;         // pipeline is 9 deep, keep some margin
    localparam int PHASES     = 8;
    localparam int PHASE_ITEMS = 244;
    localparam int BURST_LO   = 700;        // no random idle gaps for items in this window
    localparam int BURST_HI   = 1100;

    typedef enum logic [1:0] {
        OP_ITEM,
        OP_WRITE,
        OP_SYNC
    } op_kind_t;

    typedef struct {
        op_kind_t            kind;
        logic [INDEX_W-1:0]  index;
        cbpg_reg_t           reg_sel;
        logic [COORD_W-1:0]  data;
    } pending_op_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [PIXEL_W-1:0] px;
        logic signed [PIXEL_W-1:0] py;
    } curve_point_t;

    // DUT-facing signals; the driven inputs are known from time zero
    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       start        = 1'b0;
    logic [INDEX_W-1:0]         sample_index = '0;
    logic                       wr_en        = 1'b0;
    cbpg_reg_t                  wr_index     = REG_CTRL_X0;
    logic [COORD_W-1:0]         wr_data      = '0;
    logic                       busy;
    logic                       done;
    logic signed [COORD_W-1:0]  curve_x;
    logic signed [COORD_W-1:0]  curve_y;
    logic signed [PIXEL_W-1:0]  pixel_x;
    logic signed [PIXEL_W-1:0]  pixel_y;

    // Bench state
    pending_op_t                pending_ops[$];
    curve_point_t               expected_points[$];
    logic signed [COORD_W-1:0]  ctrl_pt [NUM_REGS];
    int                         mismatch_count = 0;
    int                         items_sent = 0;

    cubic_bezier_point_generator_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sample_index (sample_index),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .done         (done),
        .curve_x      (curve_x),
        .curve_y      (curve_y),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Weighted sum of four control coordinates. Weights are Q.48 and sum to 2^48,
    // so the result is rounded half up back into the coordinate format.
    function automatic logic signed [COORD_W-1:0] blend_coord(
        input logic signed [COORD_W-1:0] pt [4],
        input longint unsigned           wt [4]
    );
        logic signed [79:0] acc;
        logic signed [79:0] shifted;
        acc = '0;
        for (int k = 0; k < 4; k++)
            acc = acc + pt[k] * $signed({16'd0, wt[k]});
        acc = acc + (80'sd1 <<< (WEIGHT_FRAC_BITS - 1));
        shifted = acc >>> WEIGHT_FRAC_BITS;   // floor
        if (shifted > 80'sd32767)
            return 16'sh7fff;
        if (shifted < -80'sd32768)
            return 16'sh8000;
        return shifted[COORD_W-1:0];
    endfunction

    // Scale to screen, truncating toward zero, then offset and saturate.
    function automatic logic signed [PIXEL_W-1:0] to_screen(
        input logic signed [COORD_W-1:0] v,
        input longint                    scale,
        input longint                    offset
    );
        longint p;
        p = (longint'(v) * scale) / (longint'(1) << FRAC_BITS) + offset;
        if (p > PIX_MAX)
            p = PIX_MAX;
        if (p < PIX_MIN)
            p = PIX_MIN;
        return p[PIXEL_W-1:0];
    endfunction

    function automatic curve_point_t eval_curve_point(input logic [INDEX_W-1:0] idx);
        longint unsigned           den;
        longint unsigned           ti;
        longint unsigned           t;
        longint unsigned           u;
        longint unsigned           wt [4];
        logic signed [COORD_W-1:0] xs [4];
        logic signed [COORD_W-1:0] ys [4];
        curve_point_t              pt;
        den = (SAMPLE_CNT > 1) ? longint'(SAMPLE_CNT - 1) : 1;
        ti  = idx;
        if (ti > den)
            ti = den;                   // index past the last sample -> t = 1
        t = (ti * 65536 + den / 2) / den;
        if (t > 65536)
            t = 65536;
        u = 65536 - t;
        wt[0] = u * u * u;
        wt[1] = 3 * u * u * t;
        wt[2] = 3 * u * t * t;
        wt[3] = t * t * t;
        for (int k = 0; k < 4; k++)
        begin
            xs[k] = ctrl_pt[k];
            ys[k] = ctrl_pt[k + 4];
        end
        pt.cx = blend_coord(xs, wt);
        pt.cy = blend_coord(ys, wt);
        pt.px = to_screen(pt.cx, longint'(PIX_SCALE_X), PIX_OFF_X);
        pt.py = to_screen(pt.cy, longint'(PIX_SCALE_Y), PIX_OFF_Y);
        return pt;
    endfunction

    // ------------------------------------------------------------------
    // Driver: works through pending_ops. A sync entry holds until every
    // expected point has come back, so register writes only ever land on
    // an empty pipeline.
    // ------------------------------------------------------------------
    pending_op_t        head_op;
    logic               nxt_start;
    logic               nxt_wr;
    logic [INDEX_W-1:0] nxt_index;
    logic               no_gap;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start        <= 1'b0;
            sample_index <= '0;
            wr_en        <= 1'b0;
            for (int k = 0; k < NUM_REGS; k++)
                ctrl_pt[k] = CTRL_RESET[k];
        end
        else
        begin
            nxt_start = start;
            nxt_wr    = 1'b0;
            nxt_index = sample_index;
            // item taken at this edge: predict it with the live register copy
            if (start && !busy)
            begin
                expected_points.push_back(eval_curve_point(sample_index));
                nxt_start = 1'b0;
            end
            if (!nxt_start && pending_ops.size() > 0)
            begin
                head_op = pending_ops[0];
                case (head_op.kind)
                    OP_SYNC:
                    begin
                        if (expected_points.size() == 0 && !start)
                            void'(pending_ops.pop_front());
                    end
                    OP_WRITE:
                    begin
                        void'(pending_ops.pop_front());
                        nxt_wr   = 1'b1;
                        wr_index <= head_op.reg_sel;
                        wr_data  <= head_op.data;
                        ctrl_pt[head_op.reg_sel] = head_op.data;
                    end
                    OP_ITEM:
                    begin
                        no_gap = (items_sent >= BURST_LO && items_sent < BURST_HI);
                        if (no_gap || $urandom_range(99) >= IDLE_PCT)
                        begin
                            void'(pending_ops.pop_front());
                            nxt_start = 1'b1;
                            nxt_index = head_op.index;
                            items_sent++;
                        end
                    end
                    default: ;
                endcase
            end
            // junk on the index bus while start is low; the block must ignore it
            if (!nxt_start)
                nxt_index = INDEX_W'($urandom);
            start        <= nxt_start;
            sample_index <= nxt_index;
            wr_en        <= nxt_wr;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: done is a one-cycle strobe, compared against the oldest
    // expected point.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    curve_point_t want_pt;

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_points.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result x=%0d y=%0d px=%0d py=%0d",
                                          curve_x, curve_y, pixel_x, pixel_y));
            end
            else
            begin
                want_pt = expected_points.pop_front();
                if (curve_x !== want_pt.cx)
                    report_mismatch($sformatf("curve_x got %0d want %0d", curve_x, want_pt.cx));
                if (curve_y !== want_pt.cy)
                    report_mismatch($sformatf("curve_y got %0d want %0d", curve_y, want_pt.cy));
                if (pixel_x !== want_pt.px)
                    report_mismatch($sformatf("pixel_x got %0d want %0d", pixel_x, want_pt.px));
                if (pixel_y !== want_pt.py)
                    report_mismatch($sformatf("pixel_y got %0d want %0d", pixel_y, want_pt.py));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_item(input int idx);
        pending_op_t op;
        op.kind    = OP_ITEM;
        op.index   = INDEX_W'(idx);
        op.reg_sel = REG_CTRL_X0;
        op.data    = '0;
        pending_ops.push_back(op);
    endtask

    task automatic add_write(input cbpg_reg_t sel, input logic [COORD_W-1:0] val);
        pending_op_t op;
        op.kind    = OP_WRITE;
        op.index   = '0;
        op.reg_sel = sel;
        op.data    = val;
        pending_ops.push_back(op);
    endtask

    // Drain, then load all eight control coordinates (X0..X3, Y0..Y3).
    task automatic load_points(input logic [COORD_W-1:0] pts [NUM_REGS]);
        pending_op_t op;
        op.kind    = OP_SYNC;
        op.index   = '0;
        op.reg_sel = REG_CTRL_X0;
        op.data    = '0;
        pending_ops.push_back(op);
        // sometimes a throwaway write first: the later full load must win
        if ($urandom_range(1))
            add_write(cbpg_reg_t'($urandom_range(NUM_REGS - 1)), COORD_W'($urandom));
        for (int k = 0; k < NUM_REGS; k++)
            add_write(cbpg_reg_t'(k), pts[k]);
    endtask

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(9))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [COORD_W-1:0] pts [NUM_REGS];

        // Directed: endpoints and midpoints with the reset control points
        add_item(0);
        add_item(1);
        add_item(1023);
        add_item(1024);
        add_item(SAMPLE_CNT - 2);
        add_item(SAMPLE_CNT - 1);

        // all coordinates at the positive extreme
        for (int k = 0; k < NUM_REGS; k++)
            pts[k] = 16'h7fff;
        load_points(pts);
        add_item(0);
        add_item(1024);
        add_item(SAMPLE_CNT - 1);

        // all at the negative extreme: the weighted sum hits its lowest value
        for (int k = 0; k < NUM_REGS; k++)
            pts[k] = 16'h8000;
        load_points(pts);
        add_item(0);
        add_item(1024);
        add_item(SAMPLE_CNT - 1);

        // alternating extremes, X and Y in opposite phase
        for (int k = 0; k < 4; k++)
        begin
            pts[k]     = k[0] ? 16'h8000 : 16'h7fff;
            pts[k + 4] = k[0] ? 16'h7fff : 16'h8000;
        end
        load_points(pts);
        add_item(0);
        add_item(512);
        add_item(1024);
        add_item(1536);
        add_item(SAMPLE_CNT - 1);

        // Random phases, each with its own control points
        for (int ph = 0; ph < PHASES; ph++)
        begin
            for (int k = 0; k < NUM_REGS; k++)
                pts[k] = rand_coord();
            load_points(pts);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(4) == 0)
                    add_item($urandom_range(1) ? $urandom_range(3)
                                               : SAMPLE_CNT - 1 - $urandom_range(3));
                else
                    add_item($urandom_range(SAMPLE_CNT - 1));
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every item to go out and every result to come back
        while (pending_ops.size() > 0 || start || expected_points.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (expected_points.size() > 0)
            report_mismatch($sformatf("%0d results never arrived", expected_points.size()));

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #3_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
